// ===== rtl/wma_pkg.sv =====
// Shared types and constants of the windowed moving average block.
package wma_pkg;

    localparam int DEPTH      = 1024;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int SUM_W      = SAMPLE_W + IDX_W;
    localparam int COUNT_W    = 10;
    localparam int WCOUNT_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W  = $clog2(SAMPLE_W);

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TIME  = 2'd2;

    localparam logic                MODE_COUNT       = 1'b0;
    localparam logic [WCOUNT_W-1:0] WINDOW_COUNT_RST = 10'd10;
    localparam logic [TIME_W-1:0]   WINDOW_TIME_RST  = 32'd10000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic drop;
        logic store;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic need_drop;
        logic div_last;
    } t_status;

endpackage

// ===== rtl/windowed_moving_average.sv =====
// Top level of the windowed moving average block.
//
// This block averages a stream of timestamped 16-bit samples over a sliding
// window, which is either the last window_count samples (count mode) or all
// samples no older than window_time microseconds, ages taken as wrapping
// 32-bit differences (time mode). Samples are kept in a 1024-entry ring, so at
// most 1023 are ever held; when the ring is full the oldest is dropped before
// the new one is stored. Each input word yields exactly one output word with
// the mean of the held samples rounded half up (0 when the window is empty)
// and the number of held samples. One word is processed at a time: the word
// is latched, the oldest sample is dropped if the ring is full, the word is
// stored, the oldest samples are dropped one by one while they fall outside
// the window, the mean is divided out, and the finished word waits for the
// output register to free up before it is loaded. The next word can be
// accepted in the cycle after the load.
// Each drop is preceded by a read step because the oldest sample has to be
// fetched from the ring memory before it can be compared and subtracted, and
// the mean comes from a 16-step restoring divider, one quotient bit a cycle.
// A new input word may be accepted while the previous result still waits in
// the output register. Configuration writes take effect at once and should
// only be made while the block is idle; writes to an unused index are ignored.
// No clearing pass is needed after reset, since only words from occupied ring
// slots are ever used.
module windowed_moving_average (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [wma_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic [wma_pkg::TIME_W-1:0]       i_timestamp,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [wma_pkg::SAMPLE_W-1:0]     o_average,
    output logic [wma_pkg::COUNT_W-1:0]      o_sample_count,
    input  logic                             i_cfg_we,
    input  logic [wma_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wma_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    wma_pkg::t_cmd    cmd;
    wma_pkg::t_status status;

    logic                          r_window_mode;
    logic [wma_pkg::WCOUNT_W-1:0]  r_window_count;
    logic [wma_pkg::TIME_W-1:0]    r_window_time;

    logic                          r_out_valid;
    logic [wma_pkg::SAMPLE_W-1:0]  r_average;
    logic [wma_pkg::COUNT_W-1:0]   r_sample_count;

    logic                          out_free;
    logic [wma_pkg::SAMPLE_W-1:0]  dp_average;
    logic [wma_pkg::IDX_W-1:0]     dp_count;

    // The output register can take a new word when it is empty or when its
    // current word is being taken in this cycle.
    assign out_free = !r_out_valid || !i_stall;

    // Configuration registers keep only as many low bits as they are wide.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_mode  <= wma_pkg::MODE_COUNT;
            r_window_count <= wma_pkg::WINDOW_COUNT_RST;
            r_window_time  <= wma_pkg::WINDOW_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wma_pkg::CFG_WINDOW_MODE:  r_window_mode  <= i_cfg_data[0];
                wma_pkg::CFG_WINDOW_COUNT: r_window_count <= i_cfg_data[wma_pkg::WCOUNT_W-1:0];
                wma_pkg::CFG_WINDOW_TIME:  r_window_time  <= i_cfg_data[wma_pkg::TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Output register: holds a finished word until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_average      <= dp_average;
            r_sample_count <= wma_pkg::COUNT_W'(dp_count);
        end
    end

    wma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_stall    (o_stall),
        .o_cmd      (cmd)
    );

    wma_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sample       (i_sample),
        .i_timestamp    (i_timestamp),
        .i_window_mode  (r_window_mode),
        .i_window_count (r_window_count),
        .i_window_time  (r_window_time),
        .o_status       (status),
        .o_average      (dp_average),
        .o_count        (dp_count)
    );

    assign o_valid        = r_out_valid;
    assign o_average      = r_average;
    assign o_sample_count = r_sample_count;

endmodule

// ===== rtl/wma_ctrl.sv =====
// Sequencing state machine of the windowed moving average block.
module wma_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_out_free,
    input  wma_pkg::t_status i_status,
    output logic             o_stall,
    output wma_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_FULL_RD   = 3'd1;
    localparam logic [2:0] S_FULL_DROP = 3'd2;
    localparam logic [2:0] S_STORE     = 3'd3;
    localparam logic [2:0] S_SCAN_RD   = 3'd4;
    localparam logic [2:0] S_SCAN_CK   = 3'd5;
    localparam logic [2:0] S_DIV       = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = i_status.full ? S_FULL_RD : S_STORE;
                end
            end
            S_FULL_RD: begin
                n_state = S_FULL_DROP;
            end
            S_FULL_DROP: begin
                o_cmd.drop = 1'b1;
                n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (i_status.need_drop) begin
                    o_cmd.drop = 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/wma_dp.sv =====
// Ring memories, running sum, sample count and serial divider.
module wma_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wma_pkg::t_cmd                    i_cmd,
    input  logic [wma_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic [wma_pkg::TIME_W-1:0]       i_timestamp,
    input  logic                             i_window_mode,
    input  logic [wma_pkg::WCOUNT_W-1:0]     i_window_count,
    input  logic [wma_pkg::TIME_W-1:0]       i_window_time,
    output wma_pkg::t_status                 o_status,
    output logic [wma_pkg::SAMPLE_W-1:0]     o_average,
    output logic [wma_pkg::IDX_W-1:0]        o_count
);

    logic [wma_pkg::SAMPLE_W-1:0] r_sample_mem [wma_pkg::DEPTH];
    logic [wma_pkg::TIME_W-1:0]   r_time_mem   [wma_pkg::DEPTH];

    logic [wma_pkg::SAMPLE_W-1:0] r_in_sample;
    logic [wma_pkg::TIME_W-1:0]   r_in_time;
    logic [wma_pkg::SAMPLE_W-1:0] r_rd_sample;
    logic [wma_pkg::TIME_W-1:0]   r_rd_time;

    logic [wma_pkg::IDX_W-1:0]    r_head;
    logic [wma_pkg::IDX_W-1:0]    r_tail;
    logic [wma_pkg::SUM_W-1:0]    r_sum;
    logic [wma_pkg::IDX_W-1:0]    r_count;

    logic [wma_pkg::IDX_W:0]      r_rem;
    logic [wma_pkg::SAMPLE_W-1:0] r_quo;
    logic [wma_pkg::IDX_W:0]      r_divisor;
    logic [wma_pkg::DIV_CNT_W-1:0] r_div_cnt;

    logic [wma_pkg::SUM_W:0]      dividend;
    logic [wma_pkg::IDX_W+1:0]    trial;
    logic                         quo_bit;
    logic [wma_pkg::TIME_W-1:0]   age;

    // Ring index step; the ring wraps at the last slot.
    function automatic logic [wma_pkg::IDX_W-1:0] next_slot(
        input logic [wma_pkg::IDX_W-1:0] idx
    );
        return (idx == wma_pkg::IDX_W'(wma_pkg::DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign age = r_in_time - r_rd_time;

    always_comb begin
        o_status.full     = (r_count == wma_pkg::IDX_W'(wma_pkg::DEPTH - 1));
        o_status.div_last = (r_div_cnt == wma_pkg::DIV_CNT_W'(wma_pkg::SAMPLE_W - 1));
        if (i_window_mode == wma_pkg::MODE_COUNT) begin
            o_status.need_drop = ({1'b0, r_count} > {1'b0, i_window_count});
        end else begin
            o_status.need_drop = (r_count != '0) && (age > i_window_time);
        end
    end

    // Rounded mean is floor((2*sum + count) / (2*count)).
    assign dividend = {r_sum, 1'b0} + (wma_pkg::SUM_W + 1)'(r_count);
    assign trial    = {r_rem, r_quo[wma_pkg::SAMPLE_W-1]};
    assign quo_bit  = (trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_sample_mem[r_head] <= r_in_sample;
            r_time_mem[r_head]   <= r_in_time;
        end
        r_rd_sample <= r_sample_mem[r_tail];
        r_rd_time   <= r_time_mem[r_tail];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in_sample <= i_sample;
            r_in_time   <= i_timestamp;
        end
        if (i_cmd.div_init) begin
            r_rem     <= dividend[wma_pkg::SUM_W:wma_pkg::SAMPLE_W];
            r_quo     <= dividend[wma_pkg::SAMPLE_W-1:0];
            r_divisor <= {r_count, 1'b0};
        end else if (i_cmd.div_step) begin
            r_rem <= quo_bit ? (wma_pkg::IDX_W + 1)'(trial - {1'b0, r_divisor})
                             : trial[wma_pkg::IDX_W:0];
            r_quo <= {r_quo[wma_pkg::SAMPLE_W-2:0], quo_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_sum     <= '0;
            r_count   <= '0;
            r_div_cnt <= '0;
        end else begin
            if (i_cmd.store) begin
                r_head  <= next_slot(r_head);
                r_sum   <= r_sum + wma_pkg::SUM_W'(r_in_sample);
                r_count <= r_count + 1'b1;
            end else if (i_cmd.drop) begin
                r_tail  <= next_slot(r_tail);
                r_sum   <= r_sum - wma_pkg::SUM_W'(r_rd_sample);
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.div_init) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
        end
    end

    assign o_average = (r_count == '0) ? '0 : r_quo;
    assign o_count   = r_count;

endmodule
